// ----- sv/midi_event_select_transform_assert.svh -----
// Assertion macros for the MIDI event select and transform block.
// Included by midi_event_select_transform, which carries the concurrent assertions; no dependencies.
`ifndef MIDI_EVENT_SELECT_TRANSFORM_ASSERT_SVH
`define MIDI_EVENT_SELECT_TRANSFORM_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MEST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define MEST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/mest_pkg.sv -----
// Shared types, codes and helper functions of the MIDI event select and transform block.
// No dependencies; used by mest_div and midi_event_select_transform.
package mest_pkg;

    localparam int OPERAND_BITS_DEF = 10;
    localparam logic [7:0] NOTE_ON = 8'h90;
    localparam logic [7:0] NOTE_OFF = 8'h80;
    localparam logic [31:0] LFSR_MASK = 32'hD000_0001;
    localparam logic [6:0] DATA_TOP = 7'd127;
    localparam logic [6:0] CHAN_TOP = 7'd15;
    // Ceiling of 2^32 / 100. The high word of x * PERCENT_RECIP equals x / 100
    // (rounded down) for every x below 2^30.
    localparam logic [31:0] PERCENT_RECIP = 32'd42949673;
    localparam logic [31:0] PERCENT_HALF = 32'd50;
    localparam logic [31:0] PERCENT_TWICE = 32'd200;

    typedef struct packed {
        logic [7:0] event_kind;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [3:0] channel_number;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_kind;
        logic [6:0] out_first;
        logic [6:0] out_second;
        logic [3:0] out_channel;
        logic       was_changed;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [2:0] {
        REG_EVENT_RULES = 3'd0,
        REG_SELECT_A    = 3'd1,
        REG_SELECT_B    = 3'd2,
        REG_SELECT_CH   = 3'd3,
        REG_PROCESS_A   = 3'd4,
        REG_PROCESS_B   = 3'd5,
        REG_PROCESS_CH  = 3'd6,
        REG_RANDOM_SEED = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        TYPE_ALL     = 2'd0,
        TYPE_EQUAL   = 2'd1,
        TYPE_UNEQUAL = 2'd2
    } t_type_mode;

    typedef enum logic [2:0] {
        CMP_IGNORE  = 3'd0,
        CMP_EQUAL   = 3'd1,
        CMP_UNEQUAL = 3'd2,
        CMP_HIGHER  = 3'd3,
        CMP_LOWER   = 3'd4,
        CMP_INSIDE  = 3'd5,
        CMP_OUTSIDE = 3'd6
    } t_cmp_op;

    typedef enum logic [3:0] {
        OP_KEEP    = 4'd0,
        OP_PLUS    = 4'd1,
        OP_MINUS   = 4'd2,
        OP_PCT_MUL = 4'd3,
        OP_PCT_DIV = 4'd4,
        OP_FIX     = 4'd5,
        OP_VALUE   = 4'd6,
        OP_INVERT  = 4'd7,
        OP_SCALE   = 4'd8,
        OP_FLIP    = 4'd9,
        OP_DYNAMIC = 4'd10,
        OP_RANDOM  = 4'd11
    } t_proc_op;

    typedef enum logic [1:0] {
        FLD_A  = 2'd0,
        FLD_B  = 2'd1,
        FLD_CH = 2'd2
    } t_field;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_PREP = 2'd1,
        S_DIV  = 2'd2,
        S_DONE = 2'd3
    } t_state;

    function automatic logic [31:0] lfsr_next(input logic [31:0] r);
        logic [31:0] s;
        s = {1'b0, r[31:1]};
        if (r[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

    function automatic logic compare_pass(input logic [18:0] sel, input logic [6:0] v);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] w;
        logic       pass;
        lo = sel[10:3];
        hi = sel[18:11];
        w = {1'b0, v};
        case (t_cmp_op'(sel[2:0]))
            CMP_EQUAL:   pass = (w == lo);
            CMP_UNEQUAL: pass = (w != lo);
            CMP_HIGHER:  pass = (w > lo);
            CMP_LOWER:   pass = (w < lo);
            CMP_INSIDE:  pass = (w >= lo) && (w < hi);
            CMP_OUTSIDE: pass = !((w >= lo) && (w < hi));
            default:     pass = 1'b1;
        endcase
        return pass;
    endfunction

    function automatic logic [6:0] clamp_val(input logic signed [33:0] r, input logic is_ch);
        logic signed [33:0] top;
        logic [6:0]         res;
        top = is_ch ? 34'(CHAN_TOP) : 34'(DATA_TOP);
        if (r < 0) begin
            res = 7'd0;
        end else if (r > top) begin
            res = top[6:0];
        end else begin
            res = r[6:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/mest_div.sv -----
// Bit-serial restoring divider shared by the percent divide and random operations.
// Depends on mest_pkg for the status struct and the default divisor width.
module mest_div #(
    parameter int DIVISOR_BITS = mest_pkg::OPERAND_BITS_DEF + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [31:0]             i_dividend,
    input  logic [DIVISOR_BITS-1:0] i_divisor,
    output mest_pkg::t_div_status   o_status,
    output logic [31:0]             o_quotient,
    output logic [DIVISOR_BITS-1:0] o_remainder
);
    logic [31:0]             r_quot, n_quot;
    logic [DIVISOR_BITS-1:0] r_rem, n_rem;
    logic [DIVISOR_BITS-1:0] r_div;
    logic [4:0]              r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [DIVISOR_BITS:0]   w_part;

    // One quotient bit per cycle, most significant first.
    always_comb begin
        w_part = {r_rem, r_quot[31]};
        n_quot = {r_quot[30:0], 1'b0};
        if (w_part >= {1'b0, r_div}) begin
            w_part = w_part - {1'b0, r_div};
            n_quot[0] = 1'b1;
        end
        n_rem = w_part[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient = r_quot;
    assign o_remainder = r_rem;
endmodule

// ----- sv/midi_event_select_transform.sv -----
// MIDI event select and transform block: top level with register file and sequencer.
// Depends on mest_pkg, mest_div and midi_event_select_transform_assert.svh.
//
// Each input transfer carries one MIDI event. The event is checked against the type
// rule and the three compares in the cycle it is accepted. An event that does not
// match leaves as it came, with was_changed low. In filter mode a matching event is
// dropped and no output transfer follows. In transform mode the three fields A, B and
// channel are worked one after the other by a small sequencer around one shared
// bit-serial divider, which serves percent divide and the random modulo. Percent
// multiply divides by a constant and uses a reciprocal multiplication instead. A
// field that needs the divider passes the prep state and then waits in the divide
// state while the divider works its 32 quotient steps; a percent multiply registers
// its product in the prep state and is scaled in the divide state; any other field
// is stored straight from the prep state. The input stays stalled until the result
// has moved into the output register, so a finished result may wait for the receiver
// while the next event is already accepted. The random generator is a 32-bit Galois
// LFSR that steps once for each random field with a nonzero range, and is loaded when
// random_seed is written (zero loads one). Registers sit on the APB port at byte
// address 4*i (8*i when the operand width needs 64-bit data); pready is always high
// and reads return the register value.
module midi_event_select_transform #(
    parameter int OPERAND_BITS = mest_pkg::OPERAND_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mest_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mest_pkg::t_out_item   o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [((4 + 2 * OPERAND_BITS > 32) ? 6 : 5) - 1:0] paddr,
    input  logic [((4 + 2 * OPERAND_BITS > 32) ? 64 : 32) - 1:0] pwdata,
    output logic [((4 + 2 * OPERAND_BITS > 32) ? 64 : 32) - 1:0] prdata,
    output logic                  pready
);
    `include "midi_event_select_transform_assert.svh"

    localparam int PW = 4 + 2 * OPERAND_BITS;
    localparam int DATA_W = (PW > 32) ? 64 : 32;
    localparam int ADDR_LSB = (PW > 32) ? 3 : 2;
    localparam int ADDR_W = ADDR_LSB + 3;
    localparam int DW = OPERAND_BITS + 1;

    // Configuration registers.
    logic [19:0]   r_rules;
    logic [18:0]   r_sel_a, r_sel_b, r_sel_ch;
    logic [PW-1:0] r_proc_a, r_proc_b, r_proc_ch;
    logic [31:0]   r_seed;
    logic [31:0]   r_rand;

    logic             w_cfg_wr;
    mest_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_idx = mest_pkg::t_reg_idx'(paddr[ADDR_W-1:ADDR_LSB]);

    always_comb begin
        case (w_idx)
            mest_pkg::REG_EVENT_RULES: prdata = DATA_W'(r_rules);
            mest_pkg::REG_SELECT_A:    prdata = DATA_W'(r_sel_a);
            mest_pkg::REG_SELECT_B:    prdata = DATA_W'(r_sel_b);
            mest_pkg::REG_SELECT_CH:   prdata = DATA_W'(r_sel_ch);
            mest_pkg::REG_PROCESS_A:   prdata = DATA_W'(r_proc_a);
            mest_pkg::REG_PROCESS_B:   prdata = DATA_W'(r_proc_b);
            mest_pkg::REG_PROCESS_CH:  prdata = DATA_W'(r_proc_ch);
            mest_pkg::REG_RANDOM_SEED: prdata = DATA_W'(r_seed);
            default:                   prdata = '0;
        endcase
    end

    // Sequencer state and datapath registers.
    mest_pkg::t_state r_state, n_state;
    logic [1:0]   r_fld;
    logic [7:0]   r_kind;
    logic [6:0]   r_a, r_b, r_ch;
    logic [6:0]   r_res_a, r_res_b, r_res_ch;
    logic         r_changed;
    logic         r_use_rem;
    logic         r_use_recip;
    logic [31:0]  r_prod;
    logic [OPERAND_BITS-1:0] r_base;
    logic         r_out_valid;
    mest_pkg::t_out_item r_out;

    // Control from the sequencer.
    logic w_accept, w_start, w_go_div, w_store_direct, w_store_div, w_load_out, w_step;

    // Match decision on the incoming event.
    logic w_is_note, w_hit, w_type_ok, w_match;
    always_comb begin
        w_is_note = (i_in_data.event_kind == mest_pkg::NOTE_ON)
                 || (i_in_data.event_kind == mest_pkg::NOTE_OFF);
        w_hit = w_is_note ? (r_rules[9:2] == mest_pkg::NOTE_ON)
                          : (i_in_data.event_kind == r_rules[9:2]);
        case (mest_pkg::t_type_mode'(r_rules[1:0]))
            mest_pkg::TYPE_EQUAL:   w_type_ok = w_hit;
            mest_pkg::TYPE_UNEQUAL: w_type_ok = !w_hit;
            default:                w_type_ok = 1'b1;
        endcase
        w_match = w_type_ok
               && mest_pkg::compare_pass(r_sel_a, i_in_data.first_data)
               && mest_pkg::compare_pass(r_sel_b, i_in_data.second_data)
               && mest_pkg::compare_pass(r_sel_ch, {3'b0, i_in_data.channel_number});
    end

    // Operation setup for the current field.
    logic [PW-1:0]           w_proc;
    logic [6:0]              w_v;
    logic [OPERAND_BITS-1:0] w_p1, w_p2, w_other;
    logic                    w_is_ch;
    logic                    w_need_div, w_use_rem, w_pct_mul;
    logic [31:0]             w_dividend;
    logic [DW-1:0]           w_divisor;
    logic [OPERAND_BITS-1:0] w_base;
    logic signed [33:0]      w_direct;
    logic [31:0]             w_rand_next;

    always_comb begin
        case (mest_pkg::t_field'(r_fld))
            mest_pkg::FLD_A: begin
                w_proc = r_proc_a;
                w_v = r_a;
                w_other = r_proc_b[4 +: OPERAND_BITS];
            end
            mest_pkg::FLD_B: begin
                w_proc = r_proc_b;
                w_v = r_b;
                w_other = r_proc_a[4 +: OPERAND_BITS];
            end
            default: begin
                w_proc = r_proc_ch;
                w_v = r_ch;
                w_other = r_proc_ch[4 +: OPERAND_BITS];
            end
        endcase
        w_is_ch = (r_fld == mest_pkg::FLD_CH);
        w_p1 = w_proc[4 +: OPERAND_BITS];
        w_p2 = w_proc[4 + OPERAND_BITS +: OPERAND_BITS];
        w_rand_next = mest_pkg::lfsr_next(r_rand);
        w_need_div = 1'b0;
        w_use_rem = 1'b0;
        w_pct_mul = 1'b0;
        w_dividend = '0;
        w_divisor = '0;
        w_base = '0;
        w_direct = 34'(w_v);
        case (mest_pkg::t_proc_op'(w_proc[3:0]))
            mest_pkg::OP_PLUS:  w_direct = 34'(w_v) + 34'(w_p1);
            mest_pkg::OP_MINUS: w_direct = 34'(w_v) - 34'(w_p1);
            mest_pkg::OP_PCT_MUL: begin
                // The product is registered here and scaled by the reciprocal of
                // one hundred in the next cycle; the divider is not started.
                w_need_div = 1'b1;
                w_pct_mul = 1'b1;
                w_dividend = 32'(w_v) * 32'(w_p1) + mest_pkg::PERCENT_HALF;
            end
            mest_pkg::OP_PCT_DIV: begin
                if (w_p1 == '0) begin
                    w_direct = (w_v != 7'd0) ? 34'(mest_pkg::DATA_TOP) : 34'd0;
                end else begin
                    w_need_div = 1'b1;
                    w_dividend = 32'(w_v) * mest_pkg::PERCENT_TWICE + 32'(w_p1);
                    w_divisor = {w_p1, 1'b0};
                end
            end
            mest_pkg::OP_FIX:   w_direct = 34'(w_p1);
            mest_pkg::OP_VALUE: w_direct = 34'(w_other);
            mest_pkg::OP_INVERT: begin
                // Channel inverts around sixteen, the data bytes around 127.
                w_direct = w_is_ch ? (34'(mest_pkg::CHAN_TOP) + 34'd1 - 34'(w_v))
                                   : (34'(mest_pkg::DATA_TOP) - 34'(w_v));
            end
            mest_pkg::OP_FLIP: begin
                if (r_fld == mest_pkg::FLD_A) begin
                    w_direct = 34'(w_p1) - 34'(w_v);
                end
            end
            mest_pkg::OP_RANDOM: begin
                if (w_p2 == w_p1) begin
                    w_direct = 34'(w_p1);
                end else begin
                    w_need_div = 1'b1;
                    w_use_rem = 1'b1;
                    w_dividend = w_rand_next;
                    if (w_p2 > w_p1) begin
                        w_divisor = DW'(w_p2 - w_p1);
                        w_base = w_p1;
                    end else begin
                        w_divisor = DW'(w_p1 - w_p2);
                        w_base = w_p2;
                    end
                end
            end
            default: w_direct = 34'(w_v);
        endcase
    end

    // Shared divider.
    mest_pkg::t_div_status w_div;
    logic [31:0]           w_quot;
    logic [DW-1:0]         w_rem;

    mest_div #(
        .DIVISOR_BITS(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_status   (w_div),
        .o_quotient (w_quot),
        .o_remainder(w_rem)
    );

    logic [63:0]        w_recip;
    logic signed [33:0] w_div_val;
    logic [6:0]         w_result;
    always_comb begin
        w_recip = r_prod * mest_pkg::PERCENT_RECIP;
        if (r_use_recip) begin
            w_div_val = 34'(w_recip[63:32]);
        end else begin
            w_div_val = r_use_rem ? (34'(w_rem) + 34'(r_base)) : 34'(w_quot);
        end
        w_result = mest_pkg::clamp_val(w_store_div ? w_div_val : w_direct, w_is_ch);
    end

    // Sequencer: next state and control.
    always_comb begin
        n_state = r_state;
        w_accept = 1'b0;
        w_start = 1'b0;
        w_go_div = 1'b0;
        w_store_direct = 1'b0;
        w_store_div = 1'b0;
        w_load_out = 1'b0;
        w_step = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            mest_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    if (!w_match) begin
                        n_state = mest_pkg::S_DONE;
                    end else if (r_rules[10]) begin
                        n_state = mest_pkg::S_IDLE;
                    end else begin
                        n_state = mest_pkg::S_PREP;
                    end
                end
            end
            mest_pkg::S_PREP: begin
                if (w_need_div) begin
                    w_go_div = 1'b1;
                    w_start = !w_pct_mul;
                    w_step = w_use_rem;
                    n_state = mest_pkg::S_DIV;
                end else begin
                    w_store_direct = 1'b1;
                    n_state = (r_fld == mest_pkg::FLD_CH) ? mest_pkg::S_DONE
                                                           : mest_pkg::S_PREP;
                end
            end
            mest_pkg::S_DIV: begin
                if (w_div.done || r_use_recip) begin
                    w_store_div = 1'b1;
                    n_state = (r_fld == mest_pkg::FLD_CH) ? mest_pkg::S_DONE
                                                           : mest_pkg::S_PREP;
                end
            end
            mest_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state = mest_pkg::S_IDLE;
                end
            end
            default: n_state = mest_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mest_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers, configuration and random generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules <= 20'd590400;
            r_sel_a <= '0;
            r_sel_b <= '0;
            r_sel_ch <= '0;
            r_proc_a <= '0;
            r_proc_b <= '0;
            r_proc_ch <= '0;
            r_seed <= 32'd1;
            r_rand <= 32'd1;
            r_fld <= mest_pkg::FLD_A;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_idx)
                    mest_pkg::REG_EVENT_RULES: r_rules <= pwdata[19:0];
                    mest_pkg::REG_SELECT_A:    r_sel_a <= pwdata[18:0];
                    mest_pkg::REG_SELECT_B:    r_sel_b <= pwdata[18:0];
                    mest_pkg::REG_SELECT_CH:   r_sel_ch <= pwdata[18:0];
                    mest_pkg::REG_PROCESS_A:   r_proc_a <= pwdata[PW-1:0];
                    mest_pkg::REG_PROCESS_B:   r_proc_b <= pwdata[PW-1:0];
                    mest_pkg::REG_PROCESS_CH:  r_proc_ch <= pwdata[PW-1:0];
                    mest_pkg::REG_RANDOM_SEED: begin
                        r_seed <= pwdata[31:0];
                        r_rand <= (pwdata[31:0] != 32'd0) ? pwdata[31:0] : 32'd1;
                    end
                    default: r_seed <= r_seed;
                endcase
            end else if (w_step) begin
                r_rand <= w_rand_next;
            end
            if (w_accept) begin
                r_fld <= mest_pkg::FLD_A;
            end else if (w_store_direct || w_store_div) begin
                if (r_fld != mest_pkg::FLD_CH) begin
                    r_fld <= r_fld + 2'd1;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= (w_match && r_rules[11]) ? r_rules[19:12] : i_in_data.event_kind;
            r_a <= i_in_data.first_data;
            r_b <= i_in_data.second_data;
            r_ch <= {3'b0, i_in_data.channel_number};
            r_res_a <= i_in_data.first_data;
            r_res_b <= i_in_data.second_data;
            r_res_ch <= {3'b0, i_in_data.channel_number};
            r_changed <= w_match;
        end
        if (w_go_div) begin
            r_use_rem <= w_use_rem;
            r_use_recip <= w_pct_mul;
            r_base <= w_base;
            r_prod <= w_dividend;
        end
        if (w_store_direct || w_store_div) begin
            case (mest_pkg::t_field'(r_fld))
                mest_pkg::FLD_A: r_res_a <= w_result;
                mest_pkg::FLD_B: r_res_b <= w_result;
                default:         r_res_ch <= w_result;
            endcase
        end
        if (w_load_out) begin
            r_out.out_kind <= r_kind;
            r_out.out_first <= r_res_a;
            r_out.out_second <= r_res_b;
            r_out.out_channel <= r_res_ch[3:0];
            r_out.was_changed <= r_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // The divider only reports completion while the sequencer waits for it.
    `MEST_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, w_div.done,
        r_state == mest_pkg::S_DIV, "divider finished outside its wait state")
    // The random generator never falls into the all-zero lock-up state.
    `MEST_ASSERT(a_rand_nonzero, i_clk, i_rst_n, r_rand != 32'd0,
        "random generator reached zero")
    // The field counter never runs past the channel field.
    `MEST_ASSERT(a_fld_range, i_clk, i_rst_n, r_fld != 2'd3,
        "field counter out of range")
    // A new result is only loaded when the output register is free or being emptied.
    `MEST_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_load_out,
        !r_out_valid || !i_out_stall, "pending result overwritten")
endmodule
